/* rtl/obin_pkg.sv */
// shared types and constants for the octree point binning block
package obin_pkg;

  // fixed field widths
  localparam int CoordW   = 32;
  localparam int SlotW    = 9;
  localparam int CountW   = 32;
  localparam int DepthW   = 2;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 32;

  // default number of descent levels in the cell chain
  localparam int MaxDepthDef = 3;

  // number of counter entries
  localparam int CellStore = 1 << SlotW;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] RegMinX  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegMaxX  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegMinY  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegMaxY  = 3'd3;
  localparam logic [CfgIdxW-1:0] RegMinZ  = 3'd4;
  localparam logic [CfgIdxW-1:0] RegMaxZ  = 3'd5;
  localparam logic [CfgIdxW-1:0] RegDepth = 3'd6;

  // configuration reset values
  localparam logic signed [CoordW-1:0] CoordLowest  = 32'sh8000_0000;
  localparam logic signed [CoordW-1:0] CoordHighest = 32'sh7fff_ffff;
  localparam logic [DepthW-1:0]        DepthReset   = 2'd1;

  // input beat
  typedef struct packed {
    logic signed [CoordW-1:0] point_x;
    logic signed [CoordW-1:0] point_y;
    logic signed [CoordW-1:0] point_z;
  } in_t;

  // output beat
  typedef struct packed {
    logic [SlotW-1:0]  cell_slot;
    logic [CountW-1:0] cell_count;
    logic              first_in_cell;
  } out_t;

  // point and box travelling down the cell chain
  typedef struct packed {
    in_t                      pt;
    logic signed [CoordW-1:0] min_x;
    logic signed [CoordW-1:0] max_x;
    logic signed [CoordW-1:0] min_y;
    logic signed [CoordW-1:0] max_y;
    logic signed [CoordW-1:0] min_z;
    logic signed [CoordW-1:0] max_z;
    logic [DepthW-1:0]        depth;
    logic [SlotW-1:0]         slot;
  } desc_t;

endpackage

/* rtl/obin_cell.sv */
// one octree level: midpoint compare, box narrowing and slot append
module obin_cell import obin_pkg::*; #(
  parameter int LEVEL = 0
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  adv_i,
  input  logic  valid_i,
  input  desc_t desc_i,
  output logic  valid_o,
  output desc_t desc_o
);

  logic  valid_q;
  desc_t desc_q, desc_d;
  logic  active;
  logic  ge_x, ge_y, ge_z;
  logic signed [CoordW-1:0] mid_x, mid_y, mid_z;

  // floor of the mean, exact through a 33-bit sum
  function automatic logic signed [CoordW-1:0] mid_f(input logic signed [CoordW-1:0] a,
                                                      input logic signed [CoordW-1:0] b);
    logic signed [CoordW:0] s;
    s = {a[CoordW-1], a} + {b[CoordW-1], b};
    return s[CoordW:1];
  endfunction

  // this level only acts when the point descends this far
  assign active = ({1'b0, desc_i.depth} > 3'(LEVEL));

  assign mid_x = mid_f(desc_i.min_x, desc_i.max_x);
  assign mid_y = mid_f(desc_i.min_y, desc_i.max_y);
  assign mid_z = mid_f(desc_i.min_z, desc_i.max_z);

  assign ge_x = (desc_i.pt.point_x >= mid_x);
  assign ge_y = (desc_i.pt.point_y >= mid_y);
  assign ge_z = (desc_i.pt.point_z >= mid_z);

  // narrow the box to the octant and append its code
  always_comb begin
    desc_d = desc_i;
    if (active) begin
      if (ge_x) desc_d.min_x = mid_x; else desc_d.max_x = mid_x;
      if (ge_y) desc_d.min_y = mid_y; else desc_d.max_y = mid_y;
      if (ge_z) desc_d.min_z = mid_z; else desc_d.max_z = mid_z;
      desc_d.slot = {desc_i.slot[SlotW-4:0], ge_z, ge_y, ge_x};
    end
  end

  // stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      desc_q <= desc_d;
    end
  end

  assign valid_o = valid_q;
  assign desc_o  = desc_q;

endmodule

/* rtl/obin_count.sv */
// per-cell point counters: clearing pass, read-modify-write and output register
module obin_count import obin_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  logic [SlotW-1:0] slot_i,
  input  logic             out_ready_i,
  output logic             adv_o,
  output logic             clr_busy_o,
  output logic             out_valid_o,
  output out_t             out_data_o
);

  logic [CountW-1:0] mem_q [CellStore];

  logic             clr_busy_q;
  logic [SlotW-1:0] clr_addr_q;

  logic              u_valid_q;
  logic [SlotW-1:0]  u_slot_q;
  logic [CountW-1:0] rd_data_q;
  logic              byp_hit_q;
  logic [CountW-1:0] byp_data_q;

  logic              out_valid_q;
  out_t              out_data_q;

  logic              adv;
  logic [CountW-1:0] old_cnt, new_cnt;
  logic              wr_en;
  logic [SlotW-1:0]  wr_addr;
  logic [CountW-1:0] wr_data;

  // whole pipe moves unless a result beat is waiting on a stalled sink
  assign adv = !out_valid_q || out_ready_i;

  // old count, forwarded when the same entry is written as it is read
  assign old_cnt = byp_hit_q ? byp_data_q : rd_data_q;
  assign new_cnt = (old_cnt == '1) ? old_cnt : old_cnt + CountW'(1);

  // write port: clearing pass or counter update
  always_comb begin
    if (clr_busy_q) begin
      wr_en   = 1'b1;
      wr_addr = clr_addr_q;
      wr_data = '0;
    end else begin
      wr_en   = adv && u_valid_q;
      wr_addr = u_slot_q;
      wr_data = new_cnt;
    end
  end

  // counter memory
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rd_data_q <= mem_q[slot_i];
    end
  end

  // clearing pass after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_busy_q) begin
      clr_addr_q <= clr_addr_q + SlotW'(1);
      if (clr_addr_q == '1) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  // update stage and output register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      u_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      u_valid_q   <= valid_i;
      out_valid_q <= u_valid_q;
    end
  end

  // update stage and output register payload
  always_ff @(posedge clk_i) begin
    if (adv) begin
      u_slot_q                 <= slot_i;
      byp_hit_q                <= wr_en && (wr_addr == slot_i);
      byp_data_q               <= wr_data;
      out_data_q.cell_slot     <= u_slot_q;
      out_data_q.cell_count    <= new_cnt;
      out_data_q.first_in_cell <= (old_cnt == '0);
    end
  end

  assign adv_o       = adv;
  assign clr_busy_o  = clr_busy_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // no point may be in flight while the memory is being cleared
  a_clear_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy_q |-> !u_valid_q && !valid_i)
    else $error("point in flight during counter clearing");

  // an updated count moves into the output register
  a_update_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    u_valid_q && adv |=> out_valid_q)
    else $error("counter update lost on its way out");

  // a delivered count is never zero
  a_count_nz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_data_q.cell_count != '0)
    else $error("zero count in result beat");

  // a first point always carries a count of one
  a_first_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_data_q.first_in_cell |-> out_data_q.cell_count == CountW'(1))
    else $error("first point with count other than one");

endmodule

/* rtl/octree_point_binning.sv */
// top level: config registers, descent cell chain and cell counters
// path: an accepted point is registered in every descent cell, then in the
//   counter read register and the output register; throughput: one point per
//   cycle unless the output stalls, set by the single counter memory port pair
// reset: box spans the full coordinate range, split depth 1; the counter memory
//   is then cleared one entry per cycle, all 512 entries, with input not ready
module octree_point_binning import obin_pkg::*; #(
  parameter int MAX_DEPTH = MaxDepthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  in_t                 in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output out_t                out_data_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  logic signed [CoordW-1:0] min_x_q, max_x_q, min_y_q, max_y_q, min_z_q, max_z_q;
  logic [DepthW-1:0]        depth_q;
  logic [DepthW-1:0]        depth_eff;

  logic  adv, clr_busy;
  logic  valid_c [MAX_DEPTH+1];
  desc_t desc_c  [MAX_DEPTH+1];

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_x_q <= CoordLowest;
      max_x_q <= CoordHighest;
      min_y_q <= CoordLowest;
      max_y_q <= CoordHighest;
      min_z_q <= CoordLowest;
      max_z_q <= CoordHighest;
      depth_q <= DepthReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegMinX:  min_x_q <= cfg_data_i;
        RegMaxX:  max_x_q <= cfg_data_i;
        RegMinY:  min_y_q <= cfg_data_i;
        RegMaxY:  max_y_q <= cfg_data_i;
        RegMinZ:  min_z_q <= cfg_data_i;
        RegMaxZ:  max_z_q <= cfg_data_i;
        RegDepth: depth_q <= cfg_data_i[DepthW-1:0];
        default:  ;
      endcase
    end
  end

  // clamp depth to between one and the chain length
  always_comb begin
    depth_eff = depth_q;
    if (depth_eff == '0) depth_eff = DepthW'(1);
    if ({1'b0, depth_eff} > 3'(MAX_DEPTH)) depth_eff = DepthW'(MAX_DEPTH);
  end

  assign in_ready_o = adv && !clr_busy;

  // head of the chain: accepted beat with the full node box
  always_comb begin
    valid_c[0]       = in_valid_i && in_ready_o;
    desc_c[0].pt     = in_data_i;
    desc_c[0].min_x  = min_x_q;
    desc_c[0].max_x  = max_x_q;
    desc_c[0].min_y  = min_y_q;
    desc_c[0].max_y  = max_y_q;
    desc_c[0].min_z  = min_z_q;
    desc_c[0].max_z  = max_z_q;
    desc_c[0].depth  = depth_eff;
    desc_c[0].slot   = '0;
  end

  // one cell per octree level
  for (genvar g = 0; g < MAX_DEPTH; g++) begin : g_cell
    obin_cell #(
      .LEVEL (g)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .adv_i   (adv),
      .valid_i (valid_c[g]),
      .desc_i  (desc_c[g]),
      .valid_o (valid_c[g+1]),
      .desc_o  (desc_c[g+1])
    );
  end

  // counters and output register
  obin_count u_count (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (valid_c[MAX_DEPTH]),
    .slot_i      (desc_c[MAX_DEPTH].slot),
    .out_ready_i (out_ready_i),
    .adv_o       (adv),
    .clr_busy_o  (clr_busy),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule
